// ===== src/utf8w_pkg.sv =====
`default_nettype none

package utf8w_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 21;
  localparam int unsigned WidthW = 2;
  localparam int unsigned SizeW  = 3;
  localparam int unsigned PendW  = 2;

  // Display width codes
  localparam logic [WidthW-1:0] WIDTH_CTRL = 2'd0;
  localparam logic [WidthW-1:0] WIDTH_NORM = 2'd1;
  localparam logic [WidthW-1:0] WIDTH_WIDE = 2'd2;

  // Encoded size codes
  localparam logic [SizeW-1:0] SIZE_ONE   = 3'd1;
  localparam logic [SizeW-1:0] SIZE_TWO   = 3'd2;
  localparam logic [SizeW-1:0] SIZE_THREE = 3'd3;
  localparam logic [SizeW-1:0] SIZE_FOUR  = 3'd4;

  // Low six payload bits of a continuation byte
  localparam logic [ByteW-1:0] CONT_MASK = 8'h3F;

  // One assembled character, before classification
  typedef struct packed {
    logic [CodeW-1:0] code;
    logic             trunc;
    logic             eos;
  } char_t;

  // One finished result
  typedef struct packed {
    logic [CodeW-1:0]  code;
    logic [WidthW-1:0] width;
    logic [SizeW-1:0]  size;
    logic              trunc;
    logic              eos;
  } result_t;

endpackage

`default_nettype wire

// ===== src/utf8w_decode.sv =====
`default_nettype none

module utf8w_decode (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          accept_i,
  input  wire [utf8w_pkg::ByteW-1:0]   data_byte_i,
  input  wire                          final_byte_i,
  output logic                         char_valid_o,
  output utf8w_pkg::char_t             char_o
);
  import utf8w_pkg::*;

  logic [PendW-1:0] pend_q, pend_d;
  logic [CodeW-1:0] part_q, part_d;
  logic [CodeW-1:0] merged;
  logic [CodeW-1:0] cont_bits;
  logic             open_seq;

  assign cont_bits = CodeW'(data_byte_i & CONT_MASK);

  // Assemble the code point and pick what this beat emits
  always_comb begin
    pend_d       = pend_q;
    part_d       = part_q;
    merged       = part_q;
    open_seq     = 1'b0;
    char_valid_o = 1'b0;
    char_o.code  = '0;
    char_o.trunc = 1'b0;
    char_o.eos   = final_byte_i;

    if (pend_q == '0) begin
      case (data_byte_i) inside
        [8'hC0:8'hDF]: begin
          pend_d   = 2'd1;
          part_d   = CodeW'(data_byte_i[4:0]) << 6;
          open_seq = 1'b1;
        end
        [8'hE0:8'hEF]: begin
          pend_d   = 2'd2;
          part_d   = CodeW'(data_byte_i[3:0]) << 12;
          open_seq = 1'b1;
        end
        [8'hF0:8'hF7]: begin
          pend_d   = 2'd3;
          part_d   = CodeW'(data_byte_i[2:0]) << 18;
          open_seq = 1'b1;
        end
        default: begin
          // ASCII and stray bytes pass through as their own value
          char_valid_o = 1'b1;
          char_o.code  = CodeW'(data_byte_i);
        end
      endcase
    end else begin
      case (pend_q)
        2'd1:    merged = part_q | cont_bits;
        2'd2:    merged = part_q | (cont_bits << 6);
        default: merged = part_q | (cont_bits << 12);
      endcase
      pend_d = pend_q - 2'd1;
      if (pend_d == '0) begin
        char_valid_o = 1'b1;
        char_o.code  = merged;
        part_d       = '0;
      end else begin
        part_d   = merged;
        open_seq = 1'b1;
      end
    end

    // Drop an open sequence at end of string
    if (open_seq && final_byte_i) begin
      pend_d       = '0;
      part_d       = '0;
      char_valid_o = 1'b1;
      char_o.code  = '0;
      char_o.trunc = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      part_q <= '0;
    end else if (accept_i) begin
      pend_q <= pend_d;
      part_q <= part_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/utf8w_classify.sv =====
`default_nettype none

module utf8w_classify (
  input  utf8w_pkg::char_t   char_i,
  output utf8w_pkg::result_t res_o
);
  import utf8w_pkg::*;

  logic [CodeW-1:0]  cp;
  logic [WidthW-1:0] width;
  logic [SizeW-1:0]  size;

  assign cp = char_i.code;

  // Terminal columns: control, wide East Asian ranges, else normal
  always_comb begin
    if (cp < 21'h20 || (cp >= 21'h7F && cp < 21'hA0)) begin
      width = WIDTH_CTRL;
    end else if ((cp >= 21'h1100 && cp <= 21'h115F) ||
                 (cp >= 21'h2E80 && cp <= 21'hA4CF) ||
                 (cp >= 21'hAC00 && cp <= 21'hD7A3) ||
                 (cp >= 21'hF900 && cp <= 21'hFAFF) ||
                 (cp >= 21'hFE10 && cp <= 21'hFE6F) ||
                 (cp >= 21'hFF00 && cp <= 21'hFF60) ||
                 (cp >= 21'hFFE0 && cp <= 21'hFFE6)) begin
      width = WIDTH_WIDE;
    end else begin
      width = WIDTH_NORM;
    end
  end

  // Encoded size from the value, not from the bytes read
  always_comb begin
    if (cp < 21'h80) begin
      size = SIZE_ONE;
    end else if (cp < 21'h800) begin
      size = SIZE_TWO;
    end else if (cp < 21'h10000) begin
      size = SIZE_THREE;
    end else begin
      size = SIZE_FOUR;
    end
  end

  // A truncated result carries code 0, which classifies as control, size one
  assign res_o.code  = cp;
  assign res_o.width = width;
  assign res_o.size  = size;
  assign res_o.trunc = char_i.trunc;
  assign res_o.eos   = char_i.eos;

endmodule

`default_nettype wire

// ===== src/utf8w_out_reg.sv =====
`default_nettype none

module utf8w_out_reg (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  load_i,
  input  utf8w_pkg::result_t   res_i,
  input  wire                  out_ready_i,
  output logic                 out_valid_o,
  output logic                 free_o,
  output utf8w_pkg::result_t   res_o
);
  import utf8w_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // Free when empty or when the held beat leaves this cycle
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the payload until replaced
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== src/utf8_decode_with_width.sv =====
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid_i/in_ready_o   | data_byte_i, final_byte_i
// out     | output    | out_valid_o/out_ready_i | code_point_o, display_width_o,
//         |           |                         | char_size_o, truncated_o,
//         |           |                         | end_of_string_o
//
// One byte per cycle while in_ready_o is high; a result appears in the cycle after the byte that completes it.
// Decode and classify are combinational from the byte to the single result register.
// Reset clears the pending-byte count, the partial code and the result valid.
// The input stalls only while a result is held and out_ready_i is low.
`default_nettype none

module utf8_decode_with_width (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire  [utf8w_pkg::ByteW-1:0]         data_byte_i,
  input  wire                                 final_byte_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic [utf8w_pkg::CodeW-1:0]         code_point_o,
  output logic [utf8w_pkg::WidthW-1:0]        display_width_o,
  output logic [utf8w_pkg::SizeW-1:0]         char_size_o,
  output logic                                truncated_o,
  output logic                                end_of_string_o
);
  import utf8w_pkg::*;

  logic    accept;
  logic    char_valid;
  logic    free;
  char_t   chr;
  result_t res;
  result_t res_out;

  assign in_ready_o = free;
  assign accept     = in_valid_i && free;

  utf8w_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .char_valid_o (char_valid),
    .char_o       (chr)
  );

  utf8w_classify u_classify (
    .char_i (chr),
    .res_o  (res)
  );

  utf8w_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept && char_valid),
    .res_i       (res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .free_o      (free),
    .res_o       (res_out)
  );

  assign code_point_o    = res_out.code;
  assign display_width_o = res_out.width;
  assign char_size_o     = res_out.size;
  assign truncated_o     = res_out.trunc;
  assign end_of_string_o = res_out.eos;

endmodule

`default_nettype wire

// ===== src/utf8w_checker.sv =====
`default_nettype none

module utf8w_checker (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           in_ready_o,
  input wire                           out_valid_o,
  input wire                           out_ready_i,
  input wire [utf8w_pkg::CodeW-1:0]    code_point_o,
  input wire [utf8w_pkg::WidthW-1:0]   display_width_o,
  input wire [utf8w_pkg::SizeW-1:0]    char_size_o,
  input wire                           truncated_o,
  input wire                           end_of_string_o
);
  import utf8w_pkg::*;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(code_point_o) &&
    $stable(truncated_o) && $stable(end_of_string_o))
    else $error("result beat changed while stalled");

  // Input ready is high exactly when the result slot is free
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not track result slot");

  // A truncated beat is the fixed end-of-string marker
  a_trunc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && truncated_o |-> code_point_o == '0 &&
    display_width_o == WIDTH_CTRL && char_size_o == SIZE_ONE && end_of_string_o)
    else $error("malformed truncated beat");

  // Size follows the code point range
  a_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((code_point_o < 21'h80) == (char_size_o == SIZE_ONE)) &&
    ((code_point_o >= 21'h10000) == (char_size_o == SIZE_FOUR)))
    else $error("size does not match code point");

endmodule

bind utf8_decode_with_width utf8w_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .code_point_o    (code_point_o),
  .display_width_o (display_width_o),
  .char_size_o     (char_size_o),
  .truncated_o     (truncated_o),
  .end_of_string_o (end_of_string_o)
);

`default_nettype wire
